>>> src/lsd_pkg.sv
`default_nettype none

package lsd_pkg;

   localparam int LEDS_PER_STRIP = 256;
   localparam int CHANNELS       = 16;
   localparam int WORDS_PER_LED  = 24;
   localparam int STORE_DEPTH    = LEDS_PER_STRIP * WORDS_PER_LED;

   localparam int LED_W   = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WBIT_W  = $clog2(WORDS_PER_LED);
   localparam int WORD_W  = 13;
   localparam int TICK_W  = 16;
   localparam int DEAD_W  = 8;
   localparam int PIN_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD_LAST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_PHASE_TICK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_PHASE_TICK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_UPDATES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_PATTERN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_PATTERN     = 3'd5;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_PIXEL = 2'd1,
      FUNC_SEND  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      PIN_HOLD,
      PIN_HIGH,
      PIN_LOW,
      PIN_DATA
   } pin_act_type;

   typedef struct packed {
      logic [TICK_W-1:0] bit_period_last;
      logic [TICK_W-1:0] data_phase_tick;
      logic [TICK_W-1:0] low_phase_tick;
      logic [DEAD_W-1:0] dead_updates;
      logic [PIN_W-1:0]  high_pattern;
      logic [PIN_W-1:0]  low_pattern;
   } cfg_type;

   typedef struct packed {
      func_type                 op;
      logic [CH_W-1:0]          channel;
      logic [LED_W-1:0]         led;
      logic [WORDS_PER_LED-1:0] slice;
      logic [WORD_W-1:0]        word_total;
   } item_type;

   typedef struct packed {
      logic                     en;
      logic [LED_W-1:0]         led;
      logic [CH_W-1:0]          channel;
      logic [WORDS_PER_LED-1:0] slice;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [LED_W-1:0]  led;
      logic [WBIT_W-1:0] wbit;
   } store_rd_type;

   // word i of an LED: green then red then blue, msb first
   function automatic logic [WORDS_PER_LED-1:0] pixel_slice(input logic [7:0] red,
                                                            input logic [7:0] green,
                                                            input logic [7:0] blue);
      logic [WORDS_PER_LED-1:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s[i]      = green[7-i];
         s[8 + i]  = red[7-i];
         s[16 + i] = blue[7-i];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> src/lsd_store.sv
`default_nettype none

module lsd_store
   import lsd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_wr_type  wr,
   input  wire store_rd_type  rd,
   output logic [PIN_W-1:0]   word,
   output logic               ready
);

   logic [CHANNELS-1:0][WORDS_PER_LED-1:0] mem [LEDS_PER_STRIP];
   logic [CHANNELS-1:0][WORDS_PER_LED-1:0] rd_row_ff;
   logic [WBIT_W-1:0] rd_bit_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [LED_W-1:0]  clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LED_W'(LEDS_PER_STRIP - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.led][wr.channel] <= wr.slice;
      end
      if (rd.en) begin
         rd_row_ff <= mem[rd.led];
         rd_bit_ff <= rd.wbit;
      end
   end

   always_comb begin
      word = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         word[c] = rd_row_ff[c][rd_bit_ff];
      end
   end

   assign ready = !clr_busy_ff;

endmodule

`default_nettype wire

>>> src/lsd_front.sv
`default_nettype none

module lsd_front
   import lsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  store_ready,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // func, channel, led_index, red, green, blue, word_count, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  pop,
   output item_type                   item,
   output logic                       item_valid
);

   item_type           q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   item_type           cls;
   logic               push;
   logic [1:0]         func_f;
   logic [3:0]         channel_f;
   logic [7:0]         led_f;
   logic [7:0]         red_f, green_f, blue_f;
   logic [WORD_W-1:0]  count_f;
   logic               pixel_ok;

   assign func_f    = req_tdata[1:0];
   assign channel_f = req_tdata[5:2];
   assign led_f     = req_tdata[13:6];
   assign red_f     = req_tdata[21:14];
   assign green_f   = req_tdata[29:22];
   assign blue_f    = req_tdata[37:30];
   assign count_f   = req_tdata[50:38];

   assign pixel_ok = (int'(channel_f) < CHANNELS) && (int'(led_f) < LEDS_PER_STRIP);

   always_comb begin
      cls.channel    = CH_W'(channel_f);
      cls.led        = LED_W'(led_f);
      cls.slice      = pixel_slice(red_f, green_f, blue_f);
      cls.word_total = (int'(count_f) > STORE_DEPTH) ? WORD_W'(STORE_DEPTH) : count_f;
      case (func_f)
         FUNC_TICK:  cls.op = FUNC_TICK;
         FUNC_PIXEL: cls.op = pixel_ok ? FUNC_PIXEL : FUNC_NOP;
         FUNC_SEND:  cls.op = FUNC_SEND;
         default:    cls.op = FUNC_NOP;
      endcase
   end

   assign req_tready = store_ready && (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

>>> src/lsd_back.sv
`default_nettype none

module lsd_back
   import lsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire item_type          item,
   input  wire logic              item_valid,
   output logic                   pop,
   output store_wr_type           store_wr,
   output store_rd_type           store_rd,
   input  wire logic [PIN_W-1:0]  store_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [PIN_W-1:0]       rsp_pins,
   output logic                   rsp_busy
);

   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  tick_ff, tick_in, tick_step;
   logic [WORD_W-1:0]  widx_ff, widx_in, widx_inc;
   logic [WORD_W-1:0]  wtot_ff, wtot_in;
   logic [DEAD_W-1:0]  dead_ff, dead_in;
   logic [LED_W-1:0]   led_ff, led_in;
   logic [WBIT_W-1:0]  wbit_ff, wbit_in;
   pin_act_type        act;
   logic               advance;

   logic               out_valid_ff, out_valid_in;
   logic               out_sel_ff, out_sel_in;
   logic [PIN_W-1:0]   out_pins_ff, out_pins_in;
   logic               out_busy_ff, out_busy_in;

   assign advance   = item_valid && (!out_valid_ff || rsp_ready);
   assign pop       = advance;
   assign tick_step = (tick_ff >= cfg.bit_period_last) ? '0 : tick_ff + 1'b1;
   assign widx_inc  = widx_ff + 1'b1;

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      widx_in  = widx_ff;
      wtot_in  = wtot_ff;
      dead_in  = dead_ff;
      led_in   = led_ff;
      wbit_in  = wbit_ff;
      if (advance) begin
         case (item.op)
            FUNC_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  tick_in = tick_step;
               end
               if (phase_ff == PH_DATA) begin
                  if (tick_step == cfg.low_phase_tick) begin
                     widx_in = widx_inc;
                     if (wbit_ff == WBIT_W'(WORDS_PER_LED - 1)) begin
                        wbit_in = '0;
                        led_in  = led_ff + 1'b1;
                     end else begin
                        wbit_in = wbit_ff + 1'b1;
                     end
                     if (widx_inc >= wtot_ff) begin
                        phase_in = PH_DEAD;
                     end
                  end
               end else if (phase_ff == PH_DEAD && tick_step == '0) begin
                  if (dead_ff < cfg.dead_updates) begin
                     dead_in = dead_ff + 1'b1;
                  end else begin
                     dead_in  = '0;
                     phase_in = PH_IDLE;
                  end
               end
            end
            FUNC_SEND: begin
               if (phase_ff == PH_IDLE) begin
                  wtot_in  = item.word_total;
                  widx_in  = '0;
                  led_in   = '0;
                  wbit_in  = '0;
                  dead_in  = '0;
                  tick_in  = cfg.bit_period_last;
                  phase_in = (item.word_total == '0) ? PH_DEAD : PH_DATA;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // pin action and store access
   always_comb begin
      act = PIN_HOLD;
      if (item.op == FUNC_TICK && phase_ff == PH_DATA) begin
         if (tick_step == '0) begin
            act = PIN_HIGH;
         end
         if (tick_step == cfg.data_phase_tick) begin
            act = PIN_DATA;
         end
         if (tick_step == cfg.low_phase_tick) begin
            act = PIN_LOW;
         end
      end
      store_rd.en      = advance && (act == PIN_DATA);
      store_rd.led     = led_ff;
      store_rd.wbit    = wbit_ff;
      store_wr.en      = advance && (item.op == FUNC_PIXEL);
      store_wr.led     = item.led;
      store_wr.channel = item.channel;
      store_wr.slice   = item.slice;
   end

   // output word
   always_comb begin
      out_valid_in = out_valid_ff;
      out_sel_in   = out_sel_ff;
      out_pins_in  = out_pins_ff;
      out_busy_in  = out_busy_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_busy_in  = (phase_in != PH_IDLE);
         out_sel_in   = 1'b0;
         case (act)
            PIN_HIGH: out_pins_in = cfg.high_pattern;
            PIN_LOW:  out_pins_in = cfg.low_pattern;
            PIN_DATA: out_sel_in  = 1'b1;
            default:  out_pins_in = rsp_pins;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         widx_ff      <= '0;
         wtot_ff      <= '0;
         dead_ff      <= '0;
         led_ff       <= '0;
         wbit_ff      <= '0;
         out_valid_ff <= 1'b0;
         out_sel_ff   <= 1'b0;
         out_pins_ff  <= '0;
         out_busy_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         widx_ff      <= widx_in;
         wtot_ff      <= wtot_in;
         dead_ff      <= dead_in;
         led_ff       <= led_in;
         wbit_ff      <= wbit_in;
         out_valid_ff <= out_valid_in;
         out_sel_ff   <= out_sel_in;
         out_pins_ff  <= out_pins_in;
         out_busy_ff  <= out_busy_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pins  = out_sel_ff ? store_word : out_pins_ff;
   assign rsp_busy  = out_busy_ff;

endmodule

`default_nettype wire

>>> src/parallel_rgb_led_strip_driver.sv
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | func, channel, led_index, rgb, word_count
// rsp     | out | rsp_tvalid/tready   | pins, busy_res
// csr     | in  | csr_we              | csr_index, csr_wdata
//
// One word a cycle in and out while rsp is not stalled; a word taken on req passes
// through the two-entry queue and the output register before its result is on rsp.
// Pixel writes and data-phase reads each take one port of the frame store.
// After reset a clear pass zeroes all 256 LED rows of the frame store; req_tready stays low.
// A stalled rsp holds the back end; the two-entry queue then fills and req stalls.
`default_nettype none

module parallel_rgb_led_strip_driver
   import lsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // func[1:0], channel[5:2], led_index[13:6], red[21:14], green[29:22],
   // blue[37:30], word_count[50:38], zeros above
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // pins[15:0], busy_res[16], zeros above
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   item_type          item;
   logic              item_valid;
   logic              pop;
   logic              store_ready;
   store_wr_type      store_wr;
   store_rd_type      store_rd;
   logic [PIN_W-1:0]  store_word;
   logic [PIN_W-1:0]  rsp_pins;
   logic              rsp_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BIT_PERIOD_LAST: cfg_in.bit_period_last = csr_wdata;
            CSR_DATA_PHASE_TICK: cfg_in.data_phase_tick = csr_wdata;
            CSR_LOW_PHASE_TICK:  cfg_in.low_phase_tick  = csr_wdata;
            CSR_DEAD_UPDATES:    cfg_in.dead_updates    = csr_wdata[DEAD_W-1:0];
            CSR_HIGH_PATTERN:    cfg_in.high_pattern    = csr_wdata;
            CSR_LOW_PATTERN:     cfg_in.low_pattern     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period_last <= 16'd29;
         cfg_ff.data_phase_tick <= 16'd8;
         cfg_ff.low_phase_tick  <= 16'd17;
         cfg_ff.dead_updates    <= 8'd19;
         cfg_ff.high_pattern    <= 16'hFFFF;
         cfg_ff.low_pattern     <= 16'h0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .store_ready (store_ready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .pop         (pop),
      .item        (item),
      .item_valid  (item_valid)
   );

   lsd_store u_store (
      .clock (clock),
      .reset (reset),
      .wr    (store_wr),
      .rd    (store_rd),
      .word  (store_word),
      .ready (store_ready)
   );

   lsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_valid (item_valid),
      .pop        (pop),
      .store_wr   (store_wr),
      .store_rd   (store_rd),
      .store_word (store_word),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pins   (rsp_pins),
      .rsp_busy   (rsp_busy)
   );

   assign rsp_tdata = {7'd0, rsp_busy, rsp_pins};

endmodule

`default_nettype wire
